@@ rtl/qs_pkg.sv @@
// Shared constants and types for the quicksort sorter.
// No dependencies.
`default_nettype none
package qs_pkg;
  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int RANGE_W     = 2 * IDX_W;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef struct packed {
    idx_t hi;
    idx_t lo;
  } range_t;
endpackage
`default_nettype wire

@@ rtl/qs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module qs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/quicksort_sorter.sv @@
// Quicksort sorter top level: collect, sort in place, stream out.
// Depends on qs_pkg and qs_ram.
//
// Values are taken one beat at a time into an element RAM of DEPTH entries; the beat
// flagged last_item closes the set (beats beyond DEPTH are dropped and every result of
// that run reports dropped). While sorting and emitting, in_stall is high. The sort
// runs Hoare partitions with the first element of each range as pivot and a range
// stack held in a second RAM; every element read goes through the single read port of
// the element RAM, every swap writes both elements in turn and then restarts both
// scans, and each range adds a pop, a pivot fetch, a scan start and a push. The worst
// case (already sorted input) grows with N squared. Each result is read, registered
// and then held on the output until out_stall is low.
`default_nettype none
module quicksort_sorter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire qs_pkg::value_t       in_value,
  input  wire logic                 in_last_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output qs_pkg::value_t            out_sorted_value,
  output logic                      out_last_result,
  output logic                      out_dropped
);
  import qs_pkg::*;

  typedef enum logic [15:0] {
    S_LOAD  = 16'h0001,
    S_INIT  = 16'h0002,
    S_POP   = 16'h0004,
    S_POPW  = 16'h0008,
    S_PIV   = 16'h0010,
    S_JRD   = 16'h0020,
    S_JCHK  = 16'h0040,
    S_IRD   = 16'h0080,
    S_ICHK  = 16'h0100,
    S_SWP1  = 16'h0200,
    S_SWP2  = 16'h0400,
    S_PUSH1 = 16'h0800,
    S_PUSH2 = 16'h1000,
    S_ORD   = 16'h2000,
    S_OWT   = 16'h4000,
    S_OHLD  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   fill_r, fill_nxt;
  cnt_t   sp_r, sp_nxt;
  logic   ovf_r, ovf_nxt;
  idx_t   lo_r, lo_nxt, hi_r, hi_nxt, k_r, k_nxt;
  cnt_t   i_r, i_nxt, j_r, j_nxt;
  value_t pivot_r, pivot_nxt, vi_r, vi_nxt, vj_r, vj_nxt;
  value_t out_val_r, out_val_nxt;
  logic   out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;

  logic   st_we, rs_we;
  idx_t   st_waddr, st_raddr, rs_waddr, rs_raddr;
  value_t st_wdata, st_rdata;
  range_t rs_wdata, rs_rdata;
  idx_t   q;
  cnt_t   hi_ext, lo_ext;

  qs_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  qs_ram #(.WIDTH(RANGE_W), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  assign hi_ext = {1'b0, hi_r};
  assign lo_ext = {1'b0, lo_r};
  // split index, pulled below hi so both halves shrink
  assign q = (j_r >= hi_ext) ? hi_r - idx_t'(1) : j_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    sp_nxt        = sp_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pivot_nxt     = pivot_r;
    vi_nxt        = vi_r;
    vj_nxt        = vj_r;
    out_val_nxt   = out_val_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    st_we         = 1'b0;
    st_waddr      = fill_r[IDX_W-1:0];
    st_wdata      = in_value;
    st_raddr      = '0;
    rs_we         = 1'b0;
    rs_waddr      = sp_r[IDX_W-1:0];
    rs_wdata      = '0;
    rs_raddr      = '0;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (fill_r < cnt_t'(DEPTH)) begin
            st_we    = 1'b1;
            fill_nxt = fill_r + cnt_t'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        sp_nxt = '0;
        if (fill_r >= cnt_t'(2)) begin
          rs_we    = 1'b1;
          rs_waddr = '0;
          rs_wdata = '{hi: idx_t'(fill_r - cnt_t'(1)), lo: '0};
          sp_nxt   = cnt_t'(1);
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          sp_nxt    = sp_r - cnt_t'(1);
          rs_raddr  = idx_t'(sp_r - cnt_t'(1));
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        lo_nxt = rs_rdata.lo;
        hi_nxt = rs_rdata.hi;
        if (rs_rdata.lo >= rs_rdata.hi) begin
          state_nxt = S_POP;
        end else begin
          st_raddr  = rs_rdata.lo;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        pivot_nxt = st_rdata;
        i_nxt     = lo_ext - cnt_t'(1);
        j_nxt     = hi_ext + cnt_t'(1);
        state_nxt = S_JRD;
      end
      S_JRD: begin
        j_nxt     = j_r - cnt_t'(1);
        st_raddr  = idx_t'(j_r - cnt_t'(1));
        state_nxt = S_JCHK;
      end
      S_JCHK: begin
        if (j_r > lo_ext && pivot_r < st_rdata) begin
          j_nxt    = j_r - cnt_t'(1);
          st_raddr = idx_t'(j_r - cnt_t'(1));
        end else begin
          vj_nxt    = st_rdata;
          state_nxt = S_IRD;
        end
      end
      S_IRD: begin
        i_nxt     = i_r + cnt_t'(1);
        st_raddr  = idx_t'(i_r + cnt_t'(1));
        state_nxt = S_ICHK;
      end
      S_ICHK: begin
        if (i_r < hi_ext && pivot_r > st_rdata) begin
          i_nxt    = i_r + cnt_t'(1);
          st_raddr = idx_t'(i_r + cnt_t'(1));
        end else begin
          vi_nxt    = st_rdata;
          state_nxt = (i_r < j_r) ? S_SWP1 : S_PUSH1;
        end
      end
      S_SWP1: begin
        st_we     = 1'b1;
        st_waddr  = i_r[IDX_W-1:0];
        st_wdata  = vj_r;
        state_nxt = S_SWP2;
      end
      S_SWP2: begin
        st_we     = 1'b1;
        st_waddr  = j_r[IDX_W-1:0];
        st_wdata  = vi_r;
        state_nxt = S_JRD;
      end
      S_PUSH1: begin
        if ({1'b0, q} + cnt_t'(1) < hi_ext && sp_r < cnt_t'(DEPTH)) begin
          rs_we    = 1'b1;
          rs_wdata = '{hi: hi_r, lo: q + idx_t'(1)};
          sp_nxt   = sp_r + cnt_t'(1);
        end
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        if (lo_r < q && sp_r < cnt_t'(DEPTH)) begin
          rs_we    = 1'b1;
          rs_wdata = '{hi: q, lo: lo_r};
          sp_nxt   = sp_r + cnt_t'(1);
        end
        state_nxt = S_POP;
      end
      S_ORD: begin
        st_raddr  = k_r;
        state_nxt = S_OWT;
      end
      S_OWT: begin
        out_val_nxt   = st_rdata;
        out_last_nxt  = ({1'b0, k_r} == fill_r - cnt_t'(1));
        out_valid_nxt = 1'b1;
        state_nxt     = S_OHLD;
      end
      S_OHLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt  = '0;
            sp_nxt    = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + idx_t'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sp_r        <= sp_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pivot_r    <= pivot_nxt;
    vi_r       <= vi_nxt;
    vj_r       <= vj_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall         = (state_r != S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_val_r;
  assign out_last_result  = out_last_r;
  assign out_dropped      = ovf_r;
endmodule
`default_nettype wire

@@ rtl/qs_checker.sv @@
// Port-level checks for quicksort_sorter, bound to the top level.
// Depends on qs_pkg.
`default_nettype none
module qs_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           in_last_item,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire qs_pkg::value_t out_sorted_value,
  input wire logic           out_last_result
);
  import qs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_value))
    else $error("stalled output beat changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while results pending");

  a_close_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item |=> in_stall && !out_valid)
    else $error("set close did not start sort");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_result |=> !out_valid && !in_stall)
    else $error("run did not end after last beat");
endmodule

bind quicksort_sorter qs_checker u_qs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_last_item(in_last_item), .out_valid(out_valid), .out_stall(out_stall),
  .out_sorted_value(out_sorted_value), .out_last_result(out_last_result)
);
`default_nettype wire

@@ bench/tb_quicksort_sorter.sv @@
// Testbench for quicksort_sorter: random and directed value sets with random idling.
// Expected runs are sorted values with last and drop flags. Depends on qs_pkg and the RTL.
module tb_quicksort_sorter;
  import qs_pkg::*;

  typedef struct {
    value_t value;
    logic   last_item;
  } elem_beat_t;

  typedef struct {
    value_t sorted_value;
    logic   last_result;
    logic   dropped;
  } sorted_beat_t;

  typedef enum int {
    MODE_RANDOM     = 0,
    MODE_ASCENDING  = 1,
    MODE_DESCENDING = 2,
    MODE_DUPLICATES = 3,
    MODE_EXTREMES   = 4
  } set_mode_t;

  localparam int STALL_LIMIT = 200000;
  localparam int ITEM_TARGET = 130;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  value_t in_value;
  logic   in_last_item;
  logic   out_valid;
  logic   out_stall;
  value_t out_sorted_value;
  logic   out_last_result;
  logic   out_dropped;

  elem_beat_t   pending_beats[$];
  sorted_beat_t expected_sorted[$];
  value_t       set_values[$];
  bit           set_overflow;
  int           error_count;
  int           idle_cycles;
  int           send_gap;
  int           recv_gap;
  bit           stim_done;
  bit           drain_hold;

  quicksort_sorter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_value(in_value), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sorted_value(out_sorted_value),
    .out_last_result(out_last_result), .out_dropped(out_dropped)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Sorted order is unique for equal keys too, so a plain sort predicts the block.
  task automatic absorb_beat(input elem_beat_t b);
    value_t ordered[$];
    sorted_beat_t r;
    if (set_values.size() < DEPTH) set_values.push_back(b.value);
    else set_overflow = 1'b1;
    if (b.last_item) begin
      ordered = set_values;
      ordered.sort();
      foreach (ordered[k]) begin
        r.sorted_value = ordered[k];
        r.last_result  = (k == ordered.size() - 1);
        r.dropped      = set_overflow;
        expected_sorted.push_back(r);
      end
      set_values.delete();
      set_overflow = 1'b0;
    end
  endtask

  task automatic queue_set(input int n, input set_mode_t mode);
    elem_beat_t b;
    for (int k = 0; k < n; k++) begin
      case (mode)
        MODE_RANDOM:     b.value = $urandom();
        MODE_ASCENDING:  b.value = value_t'(k);
        MODE_DESCENDING: b.value = value_t'(n - k);
        MODE_DUPLICATES: b.value = $urandom_range(0, 3);
        default:         b.value = (k % 2) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      b.last_item = (k == n - 1);
      pending_beats.push_back(b);
    end
  endtask

  // Driver: hold the beat while stalled, draw a fresh gap per beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 12);
    end else if (in_valid && !in_stall) begin
      absorb_beat(elem_beat_t'{in_value, in_last_item});
      send_gap <= $urandom_range(0, 12) * $urandom_range(0, 1);
      if (send_gap == 0 && pending_beats.size() > 0 && !drain_hold) begin
        in_value     <= pending_beats[0].value;
        in_last_item <= pending_beats[0].last_item;
        void'(pending_beats.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_beats.size() > 0 && !drain_hold) begin
        in_valid     <= 1'b1;
        in_value     <= pending_beats[0].value;
        in_last_item <= pending_beats[0].last_item;
        void'(pending_beats.pop_front());
      end
    end
  end

  // Monitor and output stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sorted.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_sorted_value));
        end else begin
          if (out_sorted_value !== expected_sorted[0].sorted_value)
            report_mismatch($sformatf("sorted_value %h, want %h", out_sorted_value,
                                      expected_sorted[0].sorted_value));
          if (out_last_result !== expected_sorted[0].last_result)
            report_mismatch($sformatf("last_result %b, want %b", out_last_result,
                                      expected_sorted[0].last_result));
          if (out_dropped !== expected_sorted[0].dropped)
            report_mismatch($sformatf("dropped %b, want %b", out_dropped,
                                      expected_sorted[0].dropped));
          void'(expected_sorted.pop_front());
        end
        recv_gap <= $urandom_range(0, 12) * $urandom_range(0, 1);
      end
      if (recv_gap > 0) begin
        out_stall <= 1'b1;
        if (!(out_valid && !out_stall)) recv_gap <= recv_gap - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    elem_beat_t b;
    int total;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_last_item = 1'b0;
    out_stall    = 1'b0;
    error_count  = 0;
    set_overflow = 1'b0;
    stim_done    = 1'b0;
    drain_hold   = 1'b0;
    idle_cycles  = 0;
    // Directed: single element extremes, ascending, descending, duplicates.
    b = '{32'hFFFF_FFFF, 1'b1}; pending_beats.push_back(b);
    b = '{32'h0, 1'b1};         pending_beats.push_back(b);
    queue_set(2, MODE_EXTREMES);
    queue_set(6, MODE_ASCENDING);
    queue_set(6, MODE_DESCENDING);
    queue_set(5, MODE_DUPLICATES);
    total = pending_beats.size();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Pause the sender until every queued run has drained.
    wait (pending_beats.size() == 0);
    drain_hold = 1'b1;
    wait (!in_valid && expected_sorted.size() == 0 && !in_stall);
    drain_hold = 1'b0;
    // Full store with the closing beat dropped, then short random sets.
    queue_set(DEPTH + 1, MODE_RANDOM);
    total += DEPTH + 1;
    while (total < ITEM_TARGET) begin
      int n;
      n = $urandom_range(1, 12);
      if (n > ITEM_TARGET - total) n = ITEM_TARGET - total;
      queue_set(n, set_mode_t'($urandom_range(0, 4)));
      total += n;
    end
    stim_done = 1'b1;
    wait (pending_beats.size() == 0 && !in_valid && expected_sorted.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_sorted.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
